[design/bpr_pkg.sv]
package bpr_pkg;

	localparam int MAX_POINTS_DEF = 31;
	localparam int MAX_SPAN_DEF   = 65536;
	localparam int VALUE_BITS_DEF = 16;

	// Q1.16 parameter and span counters
	localparam int T_BITS    = 17;
	localparam int SPAN_BITS = 17;
	localparam logic [T_BITS-1:0] T_ONE = 17'h10000;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_LONG  = 2'd2;

	typedef struct packed {
		logic [31:0] position;
		logic [15:0] coverage;
	} in_t;

	typedef struct packed {
		logic [31:0] summit_position;
		logic [31:0] summit_value;
		logic        found;
		logic [1:0]  status;
	} out_t;

endpackage

[design/bpr_div.sv]
module bpr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] den,
	output logic [16:0] quo,
	output logic [15:0] rem,
	output logic        done
);

	logic [16:0] rem_q;
	logic [16:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic        bit_in;

	// dividend is 65536: only its top bit is set
	assign bit_in = (cnt_q == 5'd0);
	assign trial  = {rem_q[15:0], bit_in};

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd16) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, den}) begin
				rem_q <= trial - {1'b0, den};
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[15:0], 1'b0};
			end
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q[15:0];
	assign done = done_q;

endmodule

[design/bpr_cell.sv]
module bpr_cell (
	input  logic                          clk,
	input  logic                          load,
	input  logic                          step,
	input  logic [31:0]                   init,
	input  logic [31:0]                   nbr,
	input  logic [bpr_pkg::T_BITS-1:0]    t,
	output logic [31:0]                   w
);

	logic        [31:0] w_q;
	logic signed [32:0] diff;
	logic signed [50:0] prod;
	logic signed [34:0] part;
	logic signed [34:0] sum;

	// a + floor((b - a) * t / 2^16) equals (a*(1-t) + b*t) >> 16
	assign diff = $signed({1'b0, nbr}) - $signed({1'b0, w_q});
	assign prod = diff * $signed({1'b0, t});
	assign part = 35'(prod >>> 16);
	assign sum  = $signed({3'b000, w_q}) + part;

	// load control value or take one de Casteljau round
	always_ff @(posedge clk) begin
		if (load) begin
			w_q <= init;
		end else if (step) begin
			w_q <= sum[31:0];
		end
	end

	assign w = w_q;

endmodule

[design/bezier_peak_refiner_top.sv]
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  bpr_pkg::in_t  (position, coverage)
// out      output     out_valid/out_stall bpr_pkg::out_t (summit, value, found, status)
// cfg      input      cfg_valid/cfg_ready half_base (4 bits)
//
// Points load one per cycle while in_stall is low. After the last point of a run, the
// serial divider forms the step 2^16/(span-1) and hands it off; then for each of the
// span samples the cell row is loaded, takes degree de Casteljau rounds and is compared.
// Short or long spans give their result in the cycle after the last point.
// Input is stalled while a run is evaluated, a result waits or a register write
// is offered. Reset is async.
module bezier_peak_refiner_top #(
	parameter int MAX_POINTS = bpr_pkg::MAX_POINTS_DEF,
	parameter int MAX_SPAN   = bpr_pkg::MAX_SPAN_DEF,
	parameter int VALUE_BITS = bpr_pkg::VALUE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  bpr_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output bpr_pkg::out_t  out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [3:0]     cfg_data
);

	localparam int IW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int LIM = (MAX_POINTS - 1) / 2;
	localparam int TB  = bpr_pkg::T_BITS;
	localparam int SB  = bpr_pkg::SPAN_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_LOAD = 3'd2;
	localparam logic [2:0] S_RUN  = 3'd3;
	localparam logic [2:0] S_CMP  = 3'd4;

	logic [2:0]            state_q;
	logic [3:0]            half_q;
	logic [CW-1:0]         count_q;
	logic [31:0]           first_q;
	logic [VALUE_BITS-1:0] cv_q [MAX_POINTS];
	logic [SB-1:0]         span_q;
	logic [SB-1:0]         k_q;
	logic [17:0]           q_q;
	logic [16:0]           r_q;
	logic [16:0]           q0_q;
	logic [15:0]           r0_q;
	logic [TB-1:0]         t_q;
	logic [CW-1:0]         rc_q;
	logic [31:0]           best_pos_q;
	logic [31:0]           best_val_q;
	logic                  out_valid_q;
	bpr_pkg::out_t         out_q;

	logic [3:0]            half_eff;
	logic [CW-1:0]         degree;
	logic                  take_in;
	logic                  last_pt;
	logic [31:0]           first_eff;
	logic [31:0]           span;
	logic [15:0]           den;
	logic                  div_start;
	logic [16:0]           div_quo;
	logic [15:0]           div_rem;
	logic                  div_done;
	logic [TB-1:0]         t_next;
	logic [16:0]           r_sum;
	logic                  cell_load;
	logic                  cell_step;
	logic [31:0]           w [MAX_POINTS];
	logic                  out_free;
	logic [31:0]           v;

	// clamp the configured half width
	always_comb begin
		if (half_q == 4'd0) begin
			half_eff = 4'd1;
		end else if (32'(half_q) > LIM) begin
			half_eff = 4'(LIM);
		end else begin
			half_eff = half_q;
		end
	end
	assign degree = CW'({half_eff, 1'b0});

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || out_valid_q || cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign take_in   = in_valid && !in_stall;
	assign last_pt   = (count_q == degree);
	assign first_eff = (count_q == '0) ? in_data.position : first_q;
	assign span      = in_data.position - first_eff;
	assign den       = 16'(span_q - SB'(1));
	assign div_start = take_in && last_pt && span >= 32'd2 && span <= 32'(MAX_SPAN);

	bpr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.den    (den),
		.quo    (div_quo),
		.rem    (div_rem),
		.done   (div_done)
	);

	// parameter of the current sample, clamped to 1.0 and forced to 1.0 for the last one
	always_comb begin
		if (k_q == span_q - SB'(1) || q_q > 18'(bpr_pkg::T_ONE)) begin
			t_next = bpr_pkg::T_ONE;
		end else begin
			t_next = q_q[TB-1:0];
		end
	end
	assign r_sum = r_q + {1'b0, r0_q};

	assign cell_load = (state_q == S_LOAD);
	assign cell_step = (state_q == S_RUN);
	assign v         = w[0];

	// row of de Casteljau cells, each fed by its right neighbour, the last one by zero
	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
		logic [31:0] nbr;
		if (i == MAX_POINTS - 1) begin : g_end
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = w[i+1];
		end
		bpr_cell u_cell (
			.clk  (clk),
			.load (cell_load),
			.step (cell_step),
			.init (32'({cv_q[i], 16'h0000})),
			.nbr  (nbr),
			.t    (t_q),
			.w    (w[i])
		);
	end

	// store control values as they arrive
	always_ff @(posedge clk) begin
		if (take_in && count_q < CW'(MAX_POINTS)) begin
			cv_q[count_q[IW-1:0]] <= in_data.coverage[VALUE_BITS-1:0];
		end
	end

	// sequencer: load, divide, then sweep the samples; also takes register writes and flags short or long spans
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			half_q      <= 4'd1;
			count_q     <= '0;
			first_q     <= '0;
			best_pos_q  <= '0;
			best_val_q  <= '0;
			out_valid_q <= 1'b0;
			span_q      <= '0;
			k_q         <= '0;
			rc_q        <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						half_q  <= cfg_data;
						count_q <= '0;
					end else if (take_in) begin
						if (count_q == '0) begin
							first_q <= in_data.position;
						end
						if (last_pt) begin
							count_q    <= '0;
							best_pos_q <= '0;
							best_val_q <= '0;
							span_q     <= SB'(span);
							if (span < 32'd2 || span > 32'(MAX_SPAN)) begin
								out_valid_q           <= 1'b1;
								out_q.summit_position <= '0;
								out_q.summit_value    <= '0;
								out_q.found           <= 1'b0;
								out_q.status          <= (span < 32'd2) ?
									bpr_pkg::ST_SHORT : bpr_pkg::ST_LONG;
							end else begin
								state_q <= S_DIV;
							end
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						k_q     <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					rc_q    <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					rc_q <= rc_q + CW'(1);
					if (rc_q == degree - CW'(1)) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (v > best_val_q) begin
						best_val_q <= v;
						best_pos_q <= first_q + 32'(k_q);
					end
					if (k_q == span_q - SB'(1)) begin
						if (out_free) begin
							out_valid_q           <= 1'b1;
							out_q.status          <= bpr_pkg::ST_OK;
							if (v > best_val_q) begin
								out_q.summit_position <= first_q + 32'(k_q);
								out_q.summit_value    <= v;
								out_q.found           <= 1'b1;
							end else begin
								out_q.summit_position <= best_pos_q;
								out_q.summit_value    <= best_val_q;
								out_q.found           <= (best_val_q != '0);
							end
							state_q <= S_IDLE;
						end
					end else begin
						k_q     <= k_q + SB'(1);
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// step t by 65536/(span-1) with a running remainder
	always_ff @(posedge clk) begin
		if (div_done) begin
			q0_q <= div_quo;
			r0_q <= div_rem;
			q_q  <= '0;
			r_q  <= '0;
		end else if (state_q == S_CMP && k_q != span_q - SB'(1)) begin
			if (r_sum >= {1'b0, den}) begin
				r_q <= r_sum - {1'b0, den};
				q_q <= q_q + {1'b0, q0_q} + 18'd1;
			end else begin
				r_q <= r_sum;
				q_q <= q_q + {1'b0, q0_q};
			end
		end
		if (state_q == S_LOAD) begin
			t_q <= t_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

	localparam int WATCHDOG_LIMIT = 1500000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int HOLD_CYCLES    = 3000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	bpr_pkg::in_t  in_data;
	logic out_valid;
	logic out_stall;
	bpr_pkg::out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [3:0] cfg_data;

	bezier_peak_refiner_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Mirror of the block's state
	logic [3:0]  half_base_q;
	logic [15:0] point_cov [bpr_pkg::MAX_POINTS_DEF];
	logic [31:0] run_first_pos;
	int          points_loaded;

	bpr_pkg::out_t summit_q[$];
	int   error_count;
	int   items_sent;
	int   send_idle_pct;
	int   stall_pct;
	int   hold_req;
	int   hold_seen;
	int   hold_left;

	// Clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int run_half();
		if (half_base_q == 4'd0) begin
			return 1;
		end
		return (int'(half_base_q) > 15) ? 15 : int'(half_base_q);
	endfunction

	// de Casteljau walk in Q16.16, truncating each step
	function automatic logic [31:0] curve_at(int degree, logic [16:0] t);
		longint unsigned w [bpr_pkg::MAX_POINTS_DEF];
		longint unsigned u;
		u = 64'd65536 - 64'(t);
		for (int i = 0; i <= degree; i++) begin
			w[i] = 64'(point_cov[i]) << 16;
		end
		for (int r = 1; r <= degree; r++) begin
			for (int i = 0; i + r <= degree; i++) begin
				w[i] = ((w[i] * u + w[i+1] * 64'(t)) >> 16) & 64'hFFFF_FFFF;
			end
		end
		return w[0][31:0];
	endfunction

	// Take one accepted point; queue the summit when the run completes
	task automatic load_point(bpr_pkg::in_t d);
		int degree;
		logic [31:0] span;
		logic [31:0] v;
		logic [16:0] t;
		longint unsigned den;
		bpr_pkg::out_t r;
		degree = 2 * run_half();
		if (points_loaded == 0) begin
			run_first_pos = d.position;
		end
		point_cov[points_loaded] = d.coverage;
		points_loaded++;
		if (points_loaded < degree + 1) begin
			return;
		end
		points_loaded = 0;
		span = d.position - run_first_pos;
		r = '0;
		if (span < 2) begin
			r.status = bpr_pkg::ST_SHORT;
		end else if (span > 32'd65536) begin
			r.status = bpr_pkg::ST_LONG;
		end else begin
			r.status = bpr_pkg::ST_OK;
			den = 64'(span) - 1;
			for (longint unsigned k = 0; k < 64'(span); k++) begin
				t = 17'((k << 16) / den);
				if (k == 64'(span) - 1) begin
					t = bpr_pkg::T_ONE;
				end
				v = curve_at(degree, t);
				if (v > r.summit_value) begin
					r.summit_value    = v;
					r.summit_position = run_first_pos + 32'(k);
				end
			end
			r.found = (r.summit_value != 0);
		end
		summit_q.push_back(r);
	endtask

	// Offer one point, at times after a random idle gap
	task automatic send_point(logic [31:0] pos, logic [15:0] cov);
		int gap;
		bpr_pkg::in_t d;
		gap = 0;
		d.position = pos;
		d.coverage = cov;
		if ($urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 4);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= d;
		do @(posedge clk); while (in_stall);
		load_point(d);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (summit_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_half_base(logic [3:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid     <= 1'b0;
		half_base_q   = v;
		points_loaded = 0;
	endtask

	function automatic logic [15:0] pick_cov(int mode);
		case (mode)
			0: return 16'd0;
			1: return 16'($urandom);
			2: return 16'hFFFF;
			default: return 16'($urandom_range(0, 255));
		endcase
	endfunction

	// Send a whole run from first to first+span, intermediate points ascending
	task automatic send_run(logic [31:0] first, logic [31:0] span, int cov_mode);
		int n;
		logic [31:0] p;
		n = 2 * run_half() + 1;
		for (int i = 0; i < n; i++) begin
			p = first + 32'((64'(span) * 64'(i)) / 64'(n - 1));
			send_point(p, pick_cov(cov_mode));
		end
	endtask

	// Mostly well-formed runs, with short and long spans mixed in
	task automatic send_random_run();
		int kind;
		logic [31:0] span;
		kind = $urandom_range(99);
		if (kind < 80) begin
			span = ($urandom_range(9) == 0) ? $urandom_range(41, 300) : $urandom_range(2, 40);
		end else if (kind < 90) begin
			span = $urandom_range(1);
		end else begin
			span = ($urandom_range(1) == 1) ? 32'($urandom) | 32'h0001_0001 : 32'd65537;
		end
		send_run($urandom, span, $urandom_range(3));
	endtask

	// Extremes of both fields and position wrap
	task automatic test_field_extremes();
		write_half_base(4'd1);
		send_run(32'd0, 32'd2, 2);
		send_run(32'hFFFF_FFFF, 32'd3, 2);
		send_run(32'hFFFF_FF00, 32'd255, 1);
		send_point(32'h0000_0010, 16'hFFFF);
		send_point(32'h8000_0000, 16'h0000);
		send_point(32'h0000_0020, 16'h8001);
	endtask

	// Short, long and flat cases
	task automatic test_special_spans();
		write_half_base(4'd2);
		send_run(32'h0000_1000, 32'd0, 1);
		send_run(32'h0000_1000, 32'd1, 1);
		send_run(32'h0000_2000, 32'd65537, 1);
		send_run(32'h0000_3000, 32'hFFFF_FFF0, 1);
		send_run(32'h0000_4000, 32'd20, 0);
	endtask

	// Widest span at the lowest degree
	task automatic test_widest_span();
		write_half_base(4'd1);
		send_run(32'h1234_0000, 32'd65536, 1);
	endtask

	// Register write drops a part-loaded run; zero and top settings
	task automatic test_config_abort();
		write_half_base(4'd3);
		send_point(32'd100, 16'd7);
		send_point(32'd101, 16'd9);
		write_half_base(4'd0);
		send_run(32'd500, 32'd6, 1);
		write_half_base(4'd15);
		send_run(32'd900, 32'd30, 1);
	endtask

	// Hold the output for a long stretch while points keep coming
	task automatic test_backpressure();
		write_half_base(4'd1);
		hold_req++;
		for (int i = 0; i < 6; i++) begin
			send_run($urandom, $urandom_range(2, 10), 1);
		end
		drain();
	endtask

	task automatic test_random_phase(logic [3:0] hb, int idle_pct, int stall, int count);
		int stop_at;
		write_half_base(hb);
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		stop_at       = items_sent + count;
		while (items_sent < stop_at) begin
			send_random_run();
		end
	endtask

	// Output stall: long hold on request, else random per phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic void report_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch expected %0h actual %0h", $time, name, exp_v, got_v);
			error_count++;
		end
	endfunction

	// Compare each summit against the oldest pending one
	always @(posedge clk) begin
		bpr_pkg::out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (summit_q.size() == 0) begin
				$display("%0t: unexpected summit, actual %0h", $time, out_data);
				error_count++;
			end else begin
				e = summit_q.pop_front();
				report_field("summit_position", e.summit_position, out_data.summit_position);
				report_field("summit_value", e.summit_value, out_data.summit_value);
				report_field("found", 32'(e.found), 32'(out_data.found));
				report_field("status", 32'(e.status), 32'(out_data.status));
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		int quiet;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
		end
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_valid     = 1'b0;
		cfg_data      = 4'd0;
		half_base_q   = 4'd1;
		points_loaded = 0;
		run_first_pos = '0;
		error_count   = 0;
		items_sent    = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req      = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_special_spans();
		test_widest_span();
		test_config_abort();
		test_backpressure();
		test_random_phase(4'd1, 0, 0, 150);
		test_random_phase(4'd2, 46, 0, 150);
		test_random_phase(4'd15, 0, 46, 130);
		test_random_phase(4'd0, 30, 30, 150);
		test_random_phase(4'd7, 46, 0, 140);
		test_random_phase(4'd3, 0, 46, 140);
		test_random_phase(4'd5, 30, 30, 140);
		test_random_phase(4'd4, 0, 0, 60);
		drain();

		if (error_count == 0 && summit_q.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
